// ===== hdl/rtx_pkg.sv =====
// Shared constants, codes and control/status types of the retransmit tracker.
package rtx_pkg;

    localparam int TableDepthDef   = 32;
    localparam int FractionBitsDef = 4;
    localparam int MaxOut          = 32;

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_TRACK = 2'd1;
    localparam logic [1:0] CMD_ACK   = 2'd2;
    localparam logic [1:0] CMD_TICK  = 2'd3;

    localparam logic [2:0] KIND_ALLOC   = 3'd0;
    localparam logic [2:0] KIND_TRACKED = 3'd1;
    localparam logic [2:0] KIND_FULL    = 3'd2;
    localparam logic [2:0] KIND_ACK     = 3'd3;
    localparam logic [2:0] KIND_UNKNOWN = 3'd4;
    localparam logic [2:0] KIND_RETX    = 3'd5;
    localparam logic [2:0] KIND_NONE    = 3'd6;

    localparam logic [1:0] CFG_RETRY_LIMIT = 2'd0;
    localparam logic [1:0] CFG_FLOOR       = 2'd1;
    localparam logic [1:0] CFG_CEILING     = 2'd2;

    localparam logic [3:0]  RetryLimitRst = 4'd5;
    localparam logic [15:0] FloorRst      = 16'd100;
    localparam logic [15:0] CeilingRst    = 16'd3000;
    localparam logic [15:0] TimeoutRst    = 16'd200;
    localparam logic [31:0] NextSeqRst    = 32'd1;

    typedef struct packed {
        logic latch_in;
        logic scan_clr;
        logic mem_rd;
        logic eval;
        logic idx_inc;
        logic finish;
        logic est_srtt;
        logic est_var;
        logic est_rto;
        logic push;
        logic push_last;
    } t_rtx_cmd;

    typedef struct packed {
        logic [1:0] cmd;
        logic       can_push;
        logic       due;
        logic       res_valid;
        logic       stop;
        logic       hit;
    } t_rtx_stat;

endpackage

// ===== hdl/retransmit_tracker_with_rto.sv =====
// Allocate goes through dispatch and finish to its result; track and ack read and
// then evaluate each table entry in turn, and an ack hit goes on to the estimator.
// A tick scans every entry unless it stops after 32 reports, and waits while a due
// entry finds no free output slot. One item is in work at a time; a new item is
// taken in the cycle after its last result is placed, even while that result waits.
// Synchronous active-low reset clears the table's valid bits and the estimator.
module retransmit_tracker_with_rto #(
    parameter int TABLE_DEPTH   = rtx_pkg::TableDepthDef,
    parameter int FRACTION_BITS = rtx_pkg::FractionBitsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_sequence_req,
    input  logic [47:0] i_time_ms,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_kind,
    output logic [31:0] o_sequence_out,
    output logic [15:0] o_timeout_ms,
    output logic [15:0] o_smoothed_rtt_ms,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    rtx_pkg::t_rtx_cmd  w_cmd;
    rtx_pkg::t_rtx_stat w_stat;

    assign o_cfg_ready = 1'b1;

    rtx_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    rtx_dpath #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_command         (i_command),
        .i_sequence_req    (i_sequence_req),
        .i_time_ms         (i_time_ms),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_kind            (o_kind),
        .o_sequence_out    (o_sequence_out),
        .o_timeout_ms      (o_timeout_ms),
        .o_smoothed_rtt_ms (o_smoothed_rtt_ms),
        .o_last            (o_last)
    );

endmodule

// ===== hdl/rtx_ctrl.sv =====
// Controller state machine of the retransmit tracker.
module rtx_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  rtx_pkg::t_rtx_stat i_stat,
    output rtx_pkg::t_rtx_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_READ     = 4'd2;
    localparam logic [3:0] S_EVAL     = 4'd3;
    localparam logic [3:0] S_FINISH   = 4'd4;
    localparam logic [3:0] S_EST1     = 4'd5;
    localparam logic [3:0] S_EST2     = 4'd6;
    localparam logic [3:0] S_EST3     = 4'd7;
    localparam logic [3:0] S_PUSH     = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       w_tick;
    logic       w_hold;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_tick     = (i_stat.cmd == rtx_pkg::CMD_TICK);
    // A due entry can only replace the held result once that result has a free output slot.
    assign w_hold     = w_tick && i_stat.due && i_stat.res_valid && !i_stat.can_push;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_stat.cmd == rtx_pkg::CMD_ALLOC) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.scan_clr = 1'b1;
                    n_state        = S_READ;
                end
            end
            S_READ: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = S_EVAL;
            end
            S_EVAL: begin
                if (!w_hold) begin
                    o_cmd.eval = 1'b1;
                    o_cmd.push = w_tick && i_stat.due && i_stat.res_valid;
                    if (i_stat.stop) begin
                        n_state = S_FINISH;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state       = S_READ;
                    end
                end
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                if (i_stat.cmd == rtx_pkg::CMD_ACK && i_stat.hit) begin
                    n_state = S_EST1;
                end else begin
                    n_state = S_PUSH;
                end
            end
            S_EST1: begin
                o_cmd.est_srtt = 1'b1;
                n_state        = S_EST2;
            end
            S_EST2: begin
                o_cmd.est_var = 1'b1;
                n_state       = S_EST3;
            end
            S_EST3: begin
                o_cmd.est_rto = 1'b1;
                n_state       = S_PUSH;
            end
            S_PUSH: begin
                if (i_stat.can_push) begin
                    o_cmd.push      = 1'b1;
                    o_cmd.push_last = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hdl/rtx_dpath.sv =====
// Datapath of the retransmit tracker: entry table, scan, RTT estimator and result register.
module rtx_dpath #(
    parameter int TABLE_DEPTH   = rtx_pkg::TableDepthDef,
    parameter int FRACTION_BITS = rtx_pkg::FractionBitsDef
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rtx_pkg::t_rtx_cmd  i_cmd,
    output rtx_pkg::t_rtx_stat o_stat,
    input  logic [1:0]         i_command,
    input  logic [31:0]        i_sequence_req,
    input  logic [47:0]        i_time_ms,
    input  logic               i_cfg_valid,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [2:0]         o_kind,
    output logic [31:0]        o_sequence_out,
    output logic [15:0]        o_timeout_ms,
    output logic [15:0]        o_smoothed_rtt_ms,
    output logic               o_last
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int SW = 16 + FRACTION_BITS;
    localparam int CW = $clog2(rtx_pkg::MaxOut + 1);
    localparam logic [IW-1:0] IdxLast  = IW'(TABLE_DEPTH - 1);
    localparam logic [CW-1:0] CountTop = CW'(rtx_pkg::MaxOut - 1);

    // Entry table.
    logic [31:0] r_mem_seq   [TABLE_DEPTH];
    logic [47:0] r_mem_time  [TABLE_DEPTH];
    logic [3:0]  r_mem_retry [TABLE_DEPTH];
    logic [31:0] r_rd_seq;
    logic [47:0] r_rd_time;
    logic [3:0]  r_rd_retry;
    logic [TABLE_DEPTH-1:0] r_valid;

    // Latched input item.
    logic [1:0]  r_cmd;
    logic [31:0] r_seq_req;
    logic [47:0] r_now;

    // Scan state.
    logic [IW-1:0] r_idx;
    logic          r_hit;
    logic [IW-1:0] r_hit_idx;
    logic [47:0]   r_hit_time;
    logic          r_free;
    logic [IW-1:0] r_free_idx;
    logic [CW-1:0] r_count;

    // Held result.
    logic          r_res_valid;
    logic [2:0]    r_res_kind;
    logic [31:0]   r_res_seq;

    // Estimator and configuration.
    logic [15:0]   r_sample;
    logic [SW-1:0] r_srtt;
    logic [SW-1:0] r_var;
    logic [15:0]   r_cur_timeout;
    logic [31:0]   r_next_seq;
    logic [3:0]    r_retry_limit;
    logic [15:0]   r_floor;
    logic [15:0]   r_ceiling;

    // Output register.
    logic          r_out_valid;
    logic [2:0]    r_out_kind;
    logic [31:0]   r_out_seq;
    logic [15:0]   r_out_timeout;
    logic [15:0]   r_out_srtt;
    logic          r_out_last;

    logic          w_search;
    logic          w_tick;
    logic          w_match;
    logic [48:0]   w_tick_diff;
    logic          w_expired;
    logic          w_due;
    logic [48:0]   w_ack_diff;
    logic [15:0]   w_sample;
    logic          w_can_push;

    logic          w_we;
    logic [IW-1:0] w_waddr;
    logic [31:0]   w_wseq;
    logic [47:0]   w_wtime;
    logic [3:0]    w_wretry;
    logic [IW-1:0] w_slot;

    logic [SW-1:0] w_s;
    logic [SW+2:0] w_srtt_sum;
    logic [SW-1:0] w_gap;
    logic [SW+1:0] w_var_sum;
    logic [SW+2:0] w_rto_sum;
    logic [18:0]   w_rto;
    logic [18:0]   w_rto_lo;
    logic [15:0]   w_rto_cl;

    assign w_search = (r_cmd == rtx_pkg::CMD_TRACK) || (r_cmd == rtx_pkg::CMD_ACK);
    assign w_tick   = (r_cmd == rtx_pkg::CMD_TICK);
    assign w_match  = r_valid[r_idx] && (r_rd_seq == r_seq_req);

    // An entry stamped later than now never counts as expired.
    assign w_tick_diff = {1'b0, r_now} - {1'b0, r_rd_time};
    assign w_expired   = !w_tick_diff[48] && (w_tick_diff[47:0] > {32'd0, r_cur_timeout});
    assign w_due       = r_valid[r_idx] && w_expired && (r_rd_retry < r_retry_limit);

    assign w_ack_diff = {1'b0, r_now} - {1'b0, r_hit_time};
    always_comb begin
        if (w_ack_diff[48]) begin
            w_sample = 16'd0;
        end else if (|w_ack_diff[47:16]) begin
            w_sample = 16'hFFFF;
        end else begin
            w_sample = w_ack_diff[15:0];
        end
    end

    assign w_can_push = !r_out_valid || i_out_ready;
    assign w_slot     = r_hit ? r_hit_idx : r_free_idx;

    always_comb begin
        o_stat.cmd       = r_cmd;
        o_stat.can_push  = w_can_push;
        o_stat.due       = w_tick && w_due;
        o_stat.res_valid = r_res_valid;
        o_stat.hit       = r_hit;
        o_stat.stop      = (r_idx == IdxLast) || (w_search && w_match) ||
                           (w_tick && w_due && (r_count == CountTop));
    end

    // Single write port: tick re-stamps the scanned entry, track fills its slot.
    always_comb begin
        w_we     = 1'b0;
        w_waddr  = r_idx;
        w_wseq   = r_rd_seq;
        w_wtime  = r_now;
        w_wretry = r_rd_retry + 4'd1;
        if (i_cmd.eval && w_tick && w_due) begin
            w_we = 1'b1;
        end else if (i_cmd.finish && (r_cmd == rtx_pkg::CMD_TRACK) && (r_hit || r_free)) begin
            w_we     = 1'b1;
            w_waddr  = w_slot;
            w_wseq   = r_seq_req;
            w_wretry = 4'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem_seq[w_waddr]   <= w_wseq;
            r_mem_time[w_waddr]  <= w_wtime;
            r_mem_retry[w_waddr] <= w_wretry;
        end
        if (i_cmd.mem_rd) begin
            r_rd_seq   <= r_mem_seq[r_idx];
            r_rd_time  <= r_mem_time[r_idx];
            r_rd_retry <= r_mem_retry[r_idx];
        end
    end

    // Estimator arithmetic, values carry FRACTION_BITS fraction bits.
    assign w_s        = {r_sample, {FRACTION_BITS{1'b0}}};
    assign w_srtt_sum = {r_srtt, 3'b000} - {3'b000, r_srtt} + {3'b000, w_s};
    assign w_gap      = (w_s >= r_srtt) ? (w_s - r_srtt) : (r_srtt - w_s);
    assign w_var_sum  = {1'b0, r_var, 1'b0} + {2'b00, r_var} + {2'b00, w_gap};
    assign w_rto_sum  = {3'b000, r_srtt} + {1'b0, r_var, 2'b00};
    assign w_rto      = w_rto_sum[SW+2:FRACTION_BITS];
    assign w_rto_lo   = (w_rto < {3'b000, r_floor}) ? {3'b000, r_floor} : w_rto;
    // The ceiling is applied last, so it wins over a floor set above it.
    assign w_rto_cl   = (w_rto_lo > {3'b000, r_ceiling}) ? r_ceiling : w_rto_lo[15:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_cmd     <= i_command;
            r_seq_req <= i_sequence_req;
            r_now     <= i_time_ms;
        end
        if (i_cmd.eval && w_search && w_match) begin
            r_hit_idx  <= r_idx;
            r_hit_time <= r_rd_time;
        end
        if (i_cmd.eval && w_search && !r_valid[r_idx] && !r_free) begin
            r_free_idx <= r_idx;
        end
        if (i_cmd.finish && (r_cmd == rtx_pkg::CMD_ACK)) begin
            r_sample <= w_sample;
        end
        if (i_cmd.push) begin
            r_out_kind    <= r_res_kind;
            r_out_seq     <= r_res_seq;
            r_out_timeout <= r_cur_timeout;
            r_out_srtt    <= r_srtt[SW-1:FRACTION_BITS];
            r_out_last    <= i_cmd.push_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid       <= '0;
            r_idx         <= '0;
            r_hit         <= 1'b0;
            r_free        <= 1'b0;
            r_count       <= '0;
            r_res_valid   <= 1'b0;
            r_res_kind    <= rtx_pkg::KIND_NONE;
            r_res_seq     <= '0;
            r_srtt        <= '0;
            r_var         <= '0;
            r_cur_timeout <= rtx_pkg::TimeoutRst;
            r_next_seq    <= rtx_pkg::NextSeqRst;
            r_retry_limit <= rtx_pkg::RetryLimitRst;
            r_floor       <= rtx_pkg::FloorRst;
            r_ceiling     <= rtx_pkg::CeilingRst;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    rtx_pkg::CFG_RETRY_LIMIT: r_retry_limit <= i_cfg_data[3:0];
                    rtx_pkg::CFG_FLOOR:       r_floor       <= i_cfg_data;
                    rtx_pkg::CFG_CEILING:     r_ceiling     <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if (i_cmd.scan_clr) begin
                r_idx       <= '0;
                r_hit       <= 1'b0;
                r_free      <= 1'b0;
                r_count     <= '0;
                r_res_valid <= 1'b0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end

            if (i_cmd.eval) begin
                if (w_search && w_match) begin
                    r_hit <= 1'b1;
                end
                if (w_search && !r_valid[r_idx]) begin
                    r_free <= 1'b1;
                end
                if (w_tick && w_due) begin
                    r_res_valid <= 1'b1;
                    r_res_kind  <= rtx_pkg::KIND_RETX;
                    r_res_seq   <= r_rd_seq;
                    r_count     <= r_count + 1'b1;
                end
            end

            if (i_cmd.finish) begin
                case (r_cmd)
                    rtx_pkg::CMD_ALLOC: begin
                        r_res_kind <= rtx_pkg::KIND_ALLOC;
                        r_res_seq  <= r_next_seq;
                        r_next_seq <= r_next_seq + 32'd1;
                    end
                    rtx_pkg::CMD_TRACK: begin
                        r_res_seq <= r_seq_req;
                        if (r_hit || r_free) begin
                            r_valid[w_slot] <= 1'b1;
                            r_res_kind      <= rtx_pkg::KIND_TRACKED;
                        end else begin
                            r_res_kind <= rtx_pkg::KIND_FULL;
                        end
                    end
                    rtx_pkg::CMD_ACK: begin
                        r_res_seq <= r_seq_req;
                        if (r_hit) begin
                            r_valid[r_hit_idx] <= 1'b0;
                            r_res_kind         <= rtx_pkg::KIND_ACK;
                        end else begin
                            r_res_kind <= rtx_pkg::KIND_UNKNOWN;
                        end
                    end
                    rtx_pkg::CMD_TICK: begin
                        if (!r_res_valid) begin
                            r_res_kind <= rtx_pkg::KIND_NONE;
                            r_res_seq  <= '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            if (i_cmd.est_srtt) begin
                r_srtt <= (r_srtt == '0) ? w_s : w_srtt_sum[SW+2:3];
            end
            if (i_cmd.est_var) begin
                r_var <= (r_var == '0) ? {1'b0, w_s[SW-1:1]} : w_var_sum[SW+1:2];
            end
            if (i_cmd.est_rto) begin
                r_cur_timeout <= w_rto_cl;
            end

            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_kind            = r_out_kind;
    assign o_sequence_out    = r_out_seq;
    assign o_timeout_ms      = r_out_timeout;
    assign o_smoothed_rtt_ms = r_out_srtt;
    assign o_last            = r_out_last;

endmodule

// ===== hdl/rtx_chk.sv =====
// Port-level checker of the retransmit tracker and its bind to the top level.
module rtx_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  o_kind,
    input logic [31:0] o_sequence_out,
    input logic        o_last
);

    // A result beat that is not taken holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_kind) && $stable(o_sequence_out) && $stable(o_last))
        else $error("result beat changed while stalled");

    // Only retransmit reports can be followed by further results of the same item.
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind != rtx_pkg::KIND_RETX) |-> o_last)
        else $error("non-retransmit result without last");

    a_none_due: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == rtx_pkg::KIND_NONE) |-> (o_sequence_out == 32'd0))
        else $error("none-due result carries a sequence");

    // The block works on one item at a time.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken again before the item was worked");

endmodule

bind retransmit_tracker_with_rto rtx_chk u_rtx_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_kind         (o_kind),
    .o_sequence_out (o_sequence_out),
    .o_last         (o_last)
);
